// ----- rtl/bb3_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 box blur stream block.
// No dependencies; imported by bb3_ctrl, bb3_lane, bb3_outq and the top level.
package bb3_pkg;

	// Input commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
	localparam int FW_W = 11;
	localparam int FH_W = 13;
	localparam int CFG_WIDTH_RST  = 1024;
	localparam int CFG_HEIGHT_RST = 1024;

	// Pixel packing: red [23:16], green [15:8], blue [7:0]
	localparam int CH_W  = 8;
	localparam int PIX_W = 3 * CH_W;

	// Sample count of one neighborhood (1..9)
	localparam int N_W = 4;

	// Output queue
	localparam int OQ_DEPTH = 8;
	localparam int OQ_PTR_W = 3;
	localparam int OQ_CNT_W = 4;
	localparam int PEND_W   = OQ_CNT_W + 1;

	// Neighborhood masks; middle row and center column always count
	typedef struct packed {
		logic row_top;
		logic row_bot;
		logic a_left;
		logic a_right;
		logic b_left;
	} mask_t;

	// Per-item descriptor travelling down the pipeline
	typedef struct packed {
		logic           pix;
		logic           drn;
		logic           res_a;
		logic           res_b;
		logic           frame_end;
		mask_t          mask;
		logic [N_W-1:0] n_a;
		logic [N_W-1:0] n_b;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_end;
		logic            run_end;
	} result_t;

endpackage

// ----- rtl/box_blur_3x3_stream_top.sv -----
`timescale 1ns / 1ps
// 3x3 box blur over a raster RGB pixel stream (uses bb3_pkg, bb3_ctrl, bb3_ram,
// bb3_lane, bb3_outq). The block takes one input transaction per clock while
// in_stall is low: a pixel, or a drain that flushes one pixel of the last row.
// Results leave in raster order one row and one pixel behind the input; a pixel
// in the last column yields two results, so the output side needs two output
// transactions for it. A result is written into the output queue after the
// item_s1 and item_s2 registers (line store read, then lane sums; the
// per-channel rounded divide sits in front of the queue) and is offered on the
// output once it is in the queue. Three channel lanes work side by side and the
// queue (8 results) merges them; in_stall rises only when queued plus in-flight
// results could overflow it. Both line stores share one MAX_WIDTH x 48-bit RAM
// with one write and two read ports; it needs no clearing pass, since border
// masking keeps unwritten entries out of every sum.
module box_blur_3x3_stream_top import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic [CH_W-1:0]       in_red,
	input  logic [CH_W-1:0]       in_green,
	input  logic [CH_W-1:0]       in_blue,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CH_W-1:0]       out_red,
	output logic [CH_W-1:0]       out_green,
	output logic [CH_W-1:0]       out_blue,
	output logic                  frame_end,
	output logic                  run_end
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic                      accept;
	item_t                     item_s1, item_s2;
	logic [AW-1:0]             addr_s1, rd_addr_a, rd_addr_b;
	logic [PIX_W-1:0]          pix_s1;
	logic [2*PIX_W-1:0]        rd_data_a, rd_data_b, word_a, word_b, wr_data;
	logic                      fwd_a_s1, fwd_b_s1;
	logic [2*PIX_W-1:0]        fwd_data_s1;
	logic [PIX_W-1:0]          up, up2;
	logic [2:0][PIX_W-1:0]     win0_q, win1_q;
	logic [2:0][2:0][PIX_W-1:0] xwin;
	logic [2:0][CH_W-1:0]      q_a, q_b;
	logic [OQ_CNT_W-1:0]       oq_count;
	logic [PEND_W-1:0]         pend;
	result_t                   res_a, res_b, head;

	// Results already owed to the queue plus worst case for one more item
	assign pend = PEND_W'(oq_count) + PEND_W'(item_s1.res_a) + PEND_W'(item_s1.res_b)
	            + PEND_W'(item_s2.res_a) + PEND_W'(item_s2.res_b);
	assign in_stall = (pend + PEND_W'(2)) > PEND_W'(OQ_DEPTH);
	assign accept   = in_valid && !in_stall;

	bb3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.command      (command),
		.item_s1      (item_s1),
		.addr_s1      (addr_s1),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b)
	);

	// Line word: [47:24] row above, [23:0] two rows above
	assign wr_data = {pix_s1, up};

	bb3_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk       (clk),
		.wr_en     (item_s1.pix),
		.wr_addr   (addr_s1),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_data_b)
	);

	// Bypass a write landing on the same edge as the read (width 1 or 2)
	assign word_a = fwd_a_s1 ? fwd_data_s1 : rd_data_a;
	assign word_b = fwd_b_s1 ? fwd_data_s1 : rd_data_b;
	assign up     = word_a[2*PIX_W-1:PIX_W];
	assign up2    = word_a[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_a_s1 <= 1'b0;
			fwd_b_s1 <= 1'b0;
			item_s2  <= '0;
		end else begin
			fwd_a_s1 <= item_s1.pix && (addr_s1 == rd_addr_a);
			fwd_b_s1 <= item_s1.pix && (addr_s1 == rd_addr_b);
			item_s2  <= item_s1;
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_s1 <= wr_data;
		if (accept) begin
			pix_s1 <= {in_red, in_green, in_blue};
		end
		if (item_s1.pix) begin
			win0_q    <= win1_q;
			win1_q[0] <= up2;
			win1_q[1] <= up;
			win1_q[2] <= pix_s1;
		end else if (item_s1.drn) begin
			win1_q[0] <= word_a[PIX_W-1:0];
			win1_q[1] <= word_a[2*PIX_W-1:PIX_W];
		end
	end

	// Neighborhood xwin[row][col]; a drain slides along the two stored rows
	always_comb begin
		xwin = '0;
		if (item_s1.drn) begin
			xwin[0][0] = win1_q[0];
			xwin[1][0] = win1_q[1];
			xwin[0][1] = word_a[PIX_W-1:0];
			xwin[1][1] = word_a[2*PIX_W-1:PIX_W];
			xwin[0][2] = word_b[PIX_W-1:0];
			xwin[1][2] = word_b[2*PIX_W-1:PIX_W];
		end else begin
			for (int i = 0; i < 3; i++) begin
				xwin[i][0] = win0_q[i];
				xwin[i][1] = win1_q[i];
			end
			xwin[0][2] = up2;
			xwin[1][2] = up;
			xwin[2][2] = pix_s1;
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		logic [2:0][2:0][CH_W-1:0] px_ch;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					px_ch[i][j] = xwin[i][j][CH_W*(2-ch) +: CH_W];
				end
			end
		end

		bb3_lane u_lane (
			.clk    (clk),
			.px     (px_ch),
			.mask   (item_s1.mask),
			.n_a_s2 (item_s2.n_a),
			.n_b_s2 (item_s2.n_b),
			.q_a    (q_a[ch]),
			.q_b    (q_b[ch])
		);
	end

	always_comb begin
		res_a.red       = q_a[0];
		res_a.green     = q_a[1];
		res_a.blue      = q_a[2];
		res_a.frame_end = item_s2.frame_end;
		res_a.run_end   = !item_s2.res_b;
		res_b.red       = q_b[0];
		res_b.green     = q_b[1];
		res_b.blue      = q_b[2];
		res_b.frame_end = 1'b0;
		res_b.run_end   = 1'b1;
	end

	bb3_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (item_s2.res_a),
		.data_a    (res_a),
		.push_b    (item_s2.res_b),
		.data_b    (res_b),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.count     (oq_count)
	);

	assign out_red   = head.red;
	assign out_green = head.green;
	assign out_blue  = head.blue;
	assign frame_end = head.frame_end;
	assign run_end   = head.run_end;

endmodule

// ----- rtl/bb3_ram.sv -----
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
// Read during write to the same address returns the old word.
module bb3_ram #(
	parameter int WIDTH  = 48,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr_a,
	output logic [WIDTH-1:0]  rd_data_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [WIDTH-1:0]  rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// ----- rtl/bb3_ctrl.sv -----
`timescale 1ns / 1ps
// Frame control: configuration, row/column/drain counters, line store read
// addresses and the stage-1 item descriptor. Depends on bb3_pkg.
module bb3_ctrl import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int RAW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic                  command,
	output item_t                 item_s1,
	output logic [AW-1:0]         addr_s1,
	output logic [AW-1:0]         rd_addr_a,
	output logic [AW-1:0]         rd_addr_b
);

	localparam int W_RST = (MAX_WIDTH < CFG_WIDTH_RST) ? MAX_WIDTH : CFG_WIDTH_RST;
	localparam int H_RST = (MAX_HEIGHT < CFG_HEIGHT_RST) ? MAX_HEIGHT : CFG_HEIGHT_RST;

	logic [AW-1:0]  last_col_q, last_col_new;
	logic [RAW-1:0] last_row_q, last_row_new;
	logic [AW-1:0]  col_q, col_d;
	logic [RAW-1:0] row_q, row_d;
	logic [AW-1:0]  drn_q, drn_d;
	logic           draining_q, draining_d;
	logic [FW_W-1:0] fw;
	logic [FH_W-1:0] fh;
	logic           c_last, r_last, d_last;
	logic [1:0]     rows, cols_a, cols_b;
	item_t          it;

	// Effective size, clamped to 1..MAX, kept as last index
	always_comb begin
		fw = cfg_data[FW_W-1:0];
		fh = cfg_data[FH_W-1:0];
		if (fw == '0) begin
			last_col_new = '0;
		end else if (32'(fw) > 32'(MAX_WIDTH)) begin
			last_col_new = AW'(MAX_WIDTH - 1);
		end else begin
			last_col_new = AW'(fw - FW_W'(1));
		end
		if (fh == '0) begin
			last_row_new = '0;
		end else if (32'(fh) > 32'(MAX_HEIGHT)) begin
			last_row_new = RAW'(MAX_HEIGHT - 1);
		end else begin
			last_row_new = RAW'(fh - FH_W'(1));
		end
	end

	always_comb begin
		it         = '0;
		col_d      = col_q;
		row_d      = row_q;
		drn_d      = drn_q;
		draining_d = draining_q;
		c_last     = (col_q == last_col_q);
		r_last     = (row_q == last_row_q);
		d_last     = (drn_q == last_col_q);

		if (accept) begin
			if (command == CMD_DRAIN) begin
				if (draining_q) begin
					it.drn          = 1'b1;
					it.res_a        = 1'b1;
					it.frame_end    = d_last;
					it.mask.row_top = (last_row_q != '0);
					it.mask.a_left  = (drn_q != '0);
					it.mask.a_right = !d_last;
					if (d_last) begin
						draining_d = 1'b0;
						drn_d      = '0;
						col_d      = '0;
						row_d      = '0;
					end else begin
						drn_d = drn_q + AW'(1);
					end
				end
			end else if (!draining_q) begin
				it.pix          = 1'b1;
				it.res_a        = (row_q != '0) && (col_q != '0);
				it.res_b        = (row_q != '0) && c_last;
				it.mask.row_top = (row_q > RAW'(1));
				it.mask.row_bot = 1'b1;
				it.mask.a_left  = (col_q > AW'(1));
				it.mask.a_right = 1'b1;
				it.mask.b_left  = (col_q != '0);
				if (c_last) begin
					col_d = '0;
					if (r_last) begin
						row_d      = '0;
						draining_d = 1'b1;
						drn_d      = '0;
					end else begin
						row_d = row_q + RAW'(1);
					end
				end else begin
					col_d = col_q + AW'(1);
				end
			end
		end

		// Any register write restarts the frame
		if (cfg_write_en) begin
			col_d      = '0;
			row_d      = '0;
			drn_d      = '0;
			draining_d = 1'b0;
		end

		rows   = 2'd1 + 2'(it.mask.row_top) + 2'(it.mask.row_bot);
		cols_a = 2'd1 + 2'(it.mask.a_left) + 2'(it.mask.a_right);
		cols_b = 2'd1 + 2'(it.mask.b_left);
		it.n_a = N_W'(rows) * N_W'(cols_a);
		it.n_b = N_W'(rows) * N_W'(cols_b);
	end

	assign rd_addr_a = draining_q ? drn_q : col_q;
	assign rd_addr_b = drn_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= AW'(W_RST - 1);
			last_row_q <= RAW'(H_RST - 1);
			col_q      <= '0;
			row_q      <= '0;
			drn_q      <= '0;
			draining_q <= 1'b0;
			item_s1    <= '0;
		end else begin
			if (cfg_write_en && (cfg_index == REG_FRAME_WIDTH)) begin
				last_col_q <= last_col_new;
			end
			if (cfg_write_en && (cfg_index == REG_FRAME_HEIGHT)) begin
				last_row_q <= last_row_new;
			end
			col_q      <= col_d;
			row_q      <= row_d;
			drn_q      <= drn_d;
			draining_q <= draining_d;
			item_s1    <= it;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= col_q;
	end

endmodule

// ----- rtl/bb3_lane.sv -----
`timescale 1ns / 1ps
// One color channel lane: masked 3x3 sums for both result slots, then the
// rounded average (2*sum + n) / (2*n) one stage later. Depends on bb3_pkg.
module bb3_lane import bb3_pkg::*; (
	input  logic                       clk,
	input  logic [2:0][2:0][CH_W-1:0]  px,
	input  mask_t                      mask,
	input  logic [N_W-1:0]             n_a_s2,
	input  logic [N_W-1:0]             n_b_s2,
	output logic [CH_W-1:0]            q_a,
	output logic [CH_W-1:0]            q_b
);

	// ceil(2^16 / n); the error term keeps floor() exact for sums up to 255*n
	function automatic logic [16:0] recip(logic [N_W-1:0] n);
		logic [16:0] m;
		unique case (n)
			N_W'(2): m = 17'd32768;
			N_W'(3): m = 17'd21846;
			N_W'(4): m = 17'd16384;
			N_W'(5): m = 17'd13108;
			N_W'(6): m = 17'd10923;
			N_W'(7): m = 17'd9363;
			N_W'(8): m = 17'd8192;
			N_W'(9): m = 17'd7282;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

	// floor((2*sum + n) / (2*n)) == floor((sum + n/2) / n)
	function automatic logic [CH_W-1:0] round_div(logic [11:0] sum, logic [N_W-1:0] n);
		logic [12:0] num;
		logic [29:0] prod;
		num  = 13'(sum) + 13'(n >> 1);
		prod = 30'(num) * 30'(recip(n));
		return prod[16+CH_W-1:16];
	endfunction

	logic [2:0][9:0] cs;
	logic [11:0]     sum_a, sum_b;
	logic [11:0]     sum_a_s2, sum_b_s2;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cs[j] = 10'(mask.row_top ? px[0][j] : 8'd0) + 10'(px[1][j])
			      + 10'(mask.row_bot ? px[2][j] : 8'd0);
		end
		sum_a = 12'(mask.a_left ? cs[0] : 10'd0) + 12'(cs[1])
		      + 12'(mask.a_right ? cs[2] : 10'd0);
		sum_b = 12'(mask.b_left ? cs[1] : 10'd0) + 12'(cs[2]);
	end

	always_ff @(posedge clk) begin
		sum_a_s2 <= sum_a;
		sum_b_s2 <= sum_b;
	end

	assign q_a = round_div(sum_a_s2, n_a_s2);
	assign q_b = round_div(sum_b_s2, n_b_s2);

endmodule

// ----- rtl/bb3_outq.sv -----
`timescale 1ns / 1ps
// Output queue merging the lanes' results: up to two pushes per cycle in
// order, one pop per output transaction. Depends on bb3_pkg.
module bb3_outq import bb3_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_a,
	input  result_t             data_a,
	input  logic                push_b,
	input  result_t             data_b,
	input  logic                out_stall,
	output logic                out_valid,
	output result_t             head,
	output logic [OQ_CNT_W-1:0] count
);

	result_t             slot_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_b;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                pop;

	assign out_valid = (cnt_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign count     = cnt_q;
	assign pop       = out_valid && !out_stall;
	assign wr_ptr_b  = wr_ptr_q + OQ_PTR_W'(push_a);

	always_ff @(posedge clk) begin
		if (push_a) begin
			slot_q[wr_ptr_q] <= data_a;
		end
		if (push_b) begin
			slot_q[wr_ptr_b] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_a) + OQ_PTR_W'(push_b);
			rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(pop);
			cnt_q    <= cnt_q + OQ_CNT_W'(push_a) + OQ_CNT_W'(push_b) - OQ_CNT_W'(pop);
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for box_blur_3x3_stream_top: queue-fed driver, output monitor and a
// transaction-level blur predictor with its own line stores. Imports rtl/bb3_pkg.sv and instantiates the top.
module tb_top;
	import bb3_pkg::*;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 4096;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS = 650;

	typedef struct {
		logic             command;
		logic [PIX_W-1:0] rgb;
	} pixel_in_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  command;
	logic [CH_W-1:0]       in_red;
	logic [CH_W-1:0]       in_green;
	logic [CH_W-1:0]       in_blue;
	logic                  out_valid;
	logic                  out_stall;
	logic [CH_W-1:0]       out_red;
	logic [CH_W-1:0]       out_green;
	logic [CH_W-1:0]       out_blue;
	logic                  frame_end;
	logic                  run_end;

	box_blur_3x3_stream_top #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.in_red      (in_red),
		.in_green    (in_green),
		.in_blue     (in_blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.frame_end   (frame_end),
		.run_end     (run_end)
	);

	pixel_in_t pixel_feed[$];
	result_t   pending_blurs[$];

	int  error_count = 0;
	int  in_idle_pct = 30;
	int  out_idle_pct = 30;
	bit  in_taken = 1'b0;
	bit  hold_request = 1'b0;
	int  hold_left = 0;
	int  quiet_cycles = 0;
	int  random_items = 0;

	// Predictor state
	bit [PIX_W-1:0]  line_up [MAX_W];
	bit [PIX_W-1:0]  line_up2 [MAX_W];
	bit [PIX_W-1:0]  win [3][2];
	int              row_pos = 0;
	int              col_pos = 0;
	int              drain_pos = 0;
	bit              flushing = 1'b0;
	bit [FW_W-1:0]   width_reg = FW_W'(CFG_WIDTH_RST);
	bit [FH_W-1:0]   height_reg = FH_W'(CFG_HEIGHT_RST);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= 50)
			$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	function automatic int clamp_dim(input int value, input int limit);
		if (value == 0)
			return 1;
		return (value > limit) ? limit : value;
	endfunction

	// px index is 3*row + column; rok/cok bit 0 = top/left, bit 2 = bottom/right
	function automatic result_t average_window(input logic [8:0][PIX_W-1:0] px,
			input logic [2:0] rok, input logic [2:0] cok);
		int i, j, sr, sg, sb, n;
		result_t res;
		sr = 0; sg = 0; sb = 0; n = 0;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				if (rok[i] && cok[j]) begin
					sr += px[3*i+j][23:16];
					sg += px[3*i+j][15:8];
					sb += px[3*i+j][7:0];
					n++;
				end
			end
		end
		if (n == 0)
			n = 1;
		res.red = CH_W'((2 * sr + n) / (2 * n));
		res.green = CH_W'((2 * sg + n) / (2 * n));
		res.blue = CH_W'((2 * sb + n) / (2 * n));
		res.frame_end = 1'b0;
		res.run_end = 1'b0;
		return res;
	endfunction

	function automatic void restart_frame();
		row_pos = 0;
		col_pos = 0;
		drain_pos = 0;
		flushing = 1'b0;
	endfunction

	task automatic predict_blur(input logic cmd, input logic [PIX_W-1:0] pix);
		int w, h, c, rr, d, lft, rgt, i;
		logic [PIX_W-1:0] up, up2;
		logic [8:0][PIX_W-1:0] px;
		logic [2:0] rok, cok;
		result_t res_a, res_b;
		bit has_a, has_b;
		w = clamp_dim(int'(width_reg), MAX_W);
		h = clamp_dim(int'(height_reg), MAX_H);
		if (cmd == CMD_DRAIN) begin
			if (!flushing || drain_pos >= w)
				return;
			d = drain_pos;
			lft = (d >= 1) ? d - 1 : 0;
			rgt = (d + 1 < w) ? d + 1 : 0;
			px = '0;
			px[0] = line_up2[lft]; px[1] = line_up2[d]; px[2] = line_up2[rgt];
			px[3] = line_up[lft];  px[4] = line_up[d];  px[5] = line_up[rgt];
			rok = {1'b0, 1'b1, h >= 2};
			cok = {d + 1 < w, 1'b1, d >= 1};
			res_a = average_window(px, rok, cok);
			res_a.run_end = 1'b1;
			if (d + 1 >= w) begin
				res_a.frame_end = 1'b1;
				restart_frame();
			end else begin
				drain_pos = d + 1;
			end
			pending_blurs.push_back(res_a);
			return;
		end
		if (flushing)
			return;

		c = col_pos;
		rr = row_pos;
		if (c >= w)
			c = 0;
		up = line_up[c];
		up2 = line_up2[c];
		has_a = 1'b0;
		has_b = 1'b0;
		if (rr >= 1) begin
			rok = {1'b1, 1'b1, rr >= 2};
			if (c >= 1) begin
				px = '0;
				for (i = 0; i < 3; i++) begin
					px[3*i] = win[i][0];
					px[3*i+1] = win[i][1];
				end
				px[2] = up2; px[5] = up; px[8] = pix;
				cok = {1'b1, 1'b1, c >= 2};
				res_a = average_window(px, rok, cok);
				has_a = 1'b1;
			end
			// last column also closes out the pixel above it
			if (c + 1 == w) begin
				px = '0;
				for (i = 0; i < 3; i++)
					px[3*i] = win[i][1];
				px[1] = up2; px[4] = up; px[7] = pix;
				cok = {1'b0, 1'b1, c >= 1};
				res_b = average_window(px, rok, cok);
				has_b = 1'b1;
			end
		end
		if (has_a) begin
			res_a.run_end = !has_b;
			pending_blurs.push_back(res_a);
		end
		if (has_b) begin
			res_b.run_end = 1'b1;
			pending_blurs.push_back(res_b);
		end

		win[0][0] = win[0][1]; win[0][1] = up2;
		win[1][0] = win[1][1]; win[1][1] = up;
		win[2][0] = win[2][1]; win[2][1] = pix;
		line_up2[c] = up;
		line_up[c] = pix;

		c++;
		if (c >= w) begin
			c = 0;
			rr++;
			if (rr >= h) begin
				rr = 0;
				flushing = 1'b1;
				drain_pos = 0;
			end
		end
		col_pos = c;
		row_pos = rr;
	endtask

	// Input side: accept at the rising edge, drive the next transaction at the falling edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predict_blur(command, {in_red, in_green, in_blue});
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		pixel_in_t item;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (pixel_feed.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
				item = pixel_feed.pop_front();
				in_valid <= 1'b1;
				command <= item.command;
				{in_red, in_green, in_blue} <= item.rgb;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side stall, with a long hold-off when hold_request is set
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 400;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_blurs.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h %h %h",
					out_red, out_green, out_blue));
			end else begin
				want = pending_blurs.pop_front();
				if (out_red !== want.red)
					report_mismatch($sformatf("out_red %h, want %h", out_red, want.red));
				if (out_green !== want.green)
					report_mismatch($sformatf("out_green %h, want %h", out_green, want.green));
				if (out_blue !== want.blue)
					report_mismatch($sformatf("out_blue %h, want %h", out_blue, want.blue));
				if (frame_end !== want.frame_end)
					report_mismatch($sformatf("frame_end %b, want %b",
						frame_end, want.frame_end));
				if (run_end !== want.run_end)
					report_mismatch($sformatf("run_end %b, want %b", run_end, want.run_end));
			end
		end
	end

	// Watchdog: no transaction on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	task automatic push_pixel(input logic [PIX_W-1:0] rgb);
		pixel_in_t item;
		item.command = CMD_PIXEL;
		item.rgb = rgb;
		pixel_feed.push_back(item);
	endtask

	task automatic push_drain();
		pixel_in_t item;
		item.command = CMD_DRAIN;
		item.rgb = PIX_W'($urandom);
		pixel_feed.push_back(item);
	endtask

	// Waits until every transaction is sent and every result is back, then settles
	task automatic wait_idle();
		while (pixel_feed.size() != 0 || in_valid || pending_blurs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(negedge clk);
		cfg_write_en <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_reg = FW_W'(value);
		else
			height_reg = FH_W'(value);
		restart_frame();
	endtask

	task automatic set_frame(input int w_val, input int h_val);
		write_register(REG_FRAME_WIDTH, w_val);
		write_register(REG_FRAME_HEIGHT, h_val);
	endtask

	// One frame of random content; noisy adds stray transactions the block should ignore
	task automatic queue_frame(input int w, input int h, input int npix, input bit noisy);
		int i;
		for (i = 0; i < npix; i++) begin
			if (noisy && $urandom_range(19) == 0)
				push_drain();
			push_pixel(PIX_W'($urandom));
			random_items++;
		end
		for (i = 0; i < w; i++) begin
			if (noisy && $urandom_range(19) == 0)
				push_pixel(PIX_W'($urandom));
			push_drain();
			random_items++;
		end
	endtask

	initial begin
		logic [PIX_W-1:0] corner_frame [12];
		int i, k, nframes, w_val, h_val, w, h, npix;
		corner_frame = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00,
			24'h010101, 24'hFEFEFE, 24'h7F8081, 24'h000001,
			24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h808080};
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_PIXEL;
		in_red = '0;
		in_green = '0;
		in_blue = '0;
		out_stall = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: 4x3 frame with edges, corners and ignored transactions
		set_frame(4, 3);
		push_drain();
		for (i = 0; i < 12; i++)
			push_pixel(corner_frame[i]);
		push_pixel(24'hABCDEF);
		for (i = 0; i < 4; i++)
			push_drain();
		push_drain();
		wait_idle();

		// Zero width and height count as one
		set_frame(0, 0);
		push_pixel(24'hFF0080);
		push_drain();
		wait_idle();

		// Register write mid-frame restarts it
		set_frame(5, 4);
		for (i = 0; i < 7; i++)
			push_pixel(PIX_W'($urandom));
		wait_idle();

		// Oversized height, cut short by the next write
		set_frame(3, 8191);
		for (i = 0; i < 9; i++)
			push_pixel(PIX_W'($urandom));
		wait_idle();

		// Oversized width, cut short by the next write
		set_frame(2047, 2);
		for (i = 0; i < 9; i++)
			push_pixel(PIX_W'($urandom));
		wait_idle();

		// Full rate, with the receiver holding off at the start
		in_idle_pct = 0;
		out_idle_pct = 0;
		set_frame(40, 4);
		@(posedge clk);
		hold_request = 1'b1;
		queue_frame(40, 4, 160, 1'b0);
		wait_idle();
		in_idle_pct = 30;
		out_idle_pct = 30;

		random_items = 0;
		k = 0;
		while (random_items < RANDOM_ITEMS) begin
			w_val = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(1, 8);
			h_val = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(1, 6);
			if ($urandom_range(19) == 0)
				w_val = 0;
			if ($urandom_range(19) == 0)
				h_val = 0;
			set_frame(w_val, h_val);
			w = clamp_dim(w_val, MAX_W);
			h = clamp_dim(h_val, MAX_H);
			nframes = $urandom_range(1, 4);
			for (i = 0; i < nframes; i++) begin
				npix = w * h;
				// now and then a truncated frame
				if ($urandom_range(9) == 0)
					npix = $urandom_range(w * h - 1, 0);
				queue_frame(w, h, npix, $urandom_range(9) < 2);
			end
			k++;
			// sender pauses once until the output side has caught up
			if (k == 10) begin
				while (pixel_feed.size() != 0 || in_valid || pending_blurs.size() != 0)
					@(posedge clk);
			end
			wait_idle();
		end

		wait_idle();
		if (pending_blurs.size() != 0)
			report_mismatch("results never arrived");
		if (error_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/bb3_ctrl.sv
rtl/bb3_lane.sv
rtl/bb3_outq.sv
rtl/box_blur_3x3_stream_top.sv
tb/tb_top.sv
